// File: rtl/core/pste_pkg.sv
// Shared types and constants for the prefix sum tree engine.
`default_nettype none

package pste_pkg;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 10;
    localparam int SUM_W  = 64;
    localparam int SIZE_W = 11;
    localparam int K_W    = 12;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANGE  = 2'd2;

    typedef enum logic [1:0] {
        RD_ADD,
        RD_PLUS,
        RD_MINUS
    } t_rd_mode;

    typedef struct packed {
        logic     cfg_load;
        logic     clr;
        logic     load;
        logic     load_lo;
        logic     rd_en;
        t_rd_mode rd_mode;
        logic     step;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic up;
        logic is_range;
        logic walk_done;
        logic clr_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/pste_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module pste_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/pste_dpath.sv
// Datapath: index walker, partial sum store, accumulator and result register.
`default_nettype none

module pste_dpath import pste_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic [SIZE_W-1:0] i_cfg_data,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [SUM_W-1:0]  i_amount,
    input  wire logic [SIZE_W-1:0] i_range_low,
    input  wire logic [SIZE_W-1:0] i_range_high,
    output logic      [SUM_W-1:0]  o_total,
    output logic                   o_status
);

    localparam logic [SIZE_W-1:0] RESET_N =
        (DEPTH < 1024) ? SIZE_W'(DEPTH) : SIZE_W'(1024);

    logic [SIZE_W-1:0] r_n;
    logic [AW-1:0]     r_clr_addr;
    logic              r_rd_v;
    t_rd_mode          r_rd_mode;
    logic [AW-1:0]     r_wb_addr;
    logic [K_W-1:0]    r_k;
    logic              r_up;
    logic              r_err;
    logic              r_is_range;
    logic [SIZE_W-1:0] r_lo;
    logic [SUM_W-1:0]  r_amount;
    logic [SUM_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_total;
    logic              r_status;

    logic [SIZE_W-1:0] n_n;
    logic              n_err;
    logic [K_W-1:0]    n_k_load;
    logic [K_W-1:0]    n_k_low;
    logic [K_W-1:0]    n_k_step;
    logic [AW-1:0]     w_raddr;
    logic [SUM_W-1:0]  w_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [SUM_W-1:0]  w_wdata;

    assign n_n = (32'(i_cfg_data) > 32'(DEPTH)) ? SIZE_W'(DEPTH) : i_cfg_data;

    always_comb begin
        unique case (i_func)
            FUNC_ADD:    n_err = ({1'b0, i_position} >= r_n);
            FUNC_PREFIX: n_err = (i_range_high > r_n);
            FUNC_RANGE:  n_err = (i_range_high > r_n) || (i_range_low > i_range_high);
            default:     n_err = 1'b1;
        endcase
    end

    assign n_k_load = (i_func == FUNC_ADD) ? (K_W'(i_position) + K_W'(1)) : K_W'(i_range_high);
    assign n_k_low  = r_k & (~r_k + K_W'(1));
    assign n_k_step = r_up ? (r_k + n_k_low) : (r_k - n_k_low);
    assign w_raddr  = AW'(r_k - K_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n        <= RESET_N;
            r_clr_addr <= '0;
            r_rd_v     <= 1'b0;
        end else begin
            if (i_cmd.cfg_load) begin
                r_n        <= n_n;
                r_clr_addr <= '0;
            end else if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_rd_v <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k        <= n_k_load;
            r_up       <= (i_func == FUNC_ADD);
            r_err      <= n_err;
            r_is_range <= (i_func == FUNC_RANGE);
            r_lo       <= i_range_low;
            r_amount   <= i_amount;
            r_acc      <= '0;
        end else begin
            if (i_cmd.load_lo) begin
                r_k  <= K_W'(r_lo);
                r_up <= 1'b0;
            end else if (i_cmd.step) begin
                r_k <= n_k_step;
            end
            if (r_rd_v && r_rd_mode == RD_PLUS) begin
                r_acc <= r_acc + w_rdata;
            end else if (r_rd_v && r_rd_mode == RD_MINUS) begin
                r_acc <= r_acc - w_rdata;
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_mode <= i_cmd.rd_mode;
            r_wb_addr <= w_raddr;
        end
        if (i_cmd.finish) begin
            r_total  <= r_acc;
            r_status <= r_err;
        end
    end

    // read-modify-write of the upward walk lands in the cycle after its read
    assign w_we    = i_cmd.clr || (r_rd_v && r_rd_mode == RD_ADD);
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_wb_addr;
    assign w_wdata = i_cmd.clr ? '0 : (w_rdata + r_amount);

    pste_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stat.err       = r_err;
    assign o_stat.up        = r_up;
    assign o_stat.is_range  = r_is_range;
    assign o_stat.walk_done = r_up ? (r_k > K_W'(r_n)) : (r_k == '0);
    assign o_stat.clr_last  = (r_clr_addr == AW'(DEPTH - 1));

    assign o_total  = r_total;
    assign o_status = r_status;

endmodule

`default_nettype wire

// File: rtl/core/pste_ctrl.sv
// Controller: sequences clearing, tree walks and result hand-off.
`default_nettype none

module pste_ctrl import pste_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_req,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HI,
        S_LO,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.rd_mode = RD_ADD;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HI;
                end
            end
            S_HI: begin
                priority if (i_stat.err) begin
                    n_state = S_DONE;
                end else if (i_stat.walk_done && i_stat.is_range) begin
                    o_cmd.load_lo = 1'b1;
                    n_state       = S_LO;
                end else if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_mode = i_stat.up ? RD_ADD : RD_PLUS;
                    o_cmd.step    = 1'b1;
                end
            end
            S_LO: begin
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_mode = RD_MINUS;
                    o_cmd.step    = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_cfg_req) begin
            o_cmd.cfg_load = 1'b1;
            n_state        = S_CLEAR;
        end
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/prefix_sum_tree_engine_core.sv
// Top level of the prefix sum tree engine: binary indexed tree over a partial sum store.
//
//  channel   direction  signals                      payload
//  s_axis    in         s_axis_tvalid/tready         tdata: position, amount, range_low,
//                                                    range_high; tuser: func
//  m_axis    out        m_axis_tvalid/tready         tdata: total; tuser: status
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_data: size_in_use
//
//  From request to result an item walks the index steps of the tree, one store read per
//  cycle; a range sum walks both bounds. Reset and every size write start a clearing
//  pass over all DEPTH store entries, one entry a cycle, with s_axis_tready low. A waiting
//  result does not block the next request; only the hand-off of the following result
//  waits for m_axis_tready.
`default_nettype none

module prefix_sum_tree_engine_core import pste_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SIZE_W-1:0] i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: position[9:0], amount[73:10], range_low[84:74], range_high[95:85]
    input  wire logic [95:0]       s_axis_tdata,
    // tuser: func[1:0]
    input  wire logic [1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // tdata: total[63:0]
    output logic      [63:0]       m_axis_tdata,
    // tuser: status[0]
    output logic      [0:0]        m_axis_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_cfg_req;
    logic     w_status;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_req   = i_cfg_valid && o_cfg_ready;

    pste_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_req   (w_cfg_req),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    pste_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_data   (i_cfg_data),
        .i_func       (s_axis_tuser),
        .i_position   (s_axis_tdata[9:0]),
        .i_amount     (s_axis_tdata[73:10]),
        .i_range_low  (s_axis_tdata[84:74]),
        .i_range_high (s_axis_tdata[95:85]),
        .o_total      (m_axis_tdata),
        .o_status     (w_status)
    );

    assign m_axis_tuser = w_status;

`ifndef NO_ASSERTIONS
    a_clr_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    a_rd_not_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> !w_cmd.clr)
        else $error("store read during clearing pass");

    a_cfg_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_req |=> !s_axis_tready)
        else $error("size write did not start clearing pass");

    a_err_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("error result carries non-zero total");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the prefix sum tree engine core.
`timescale 1ns / 1ps

module tb_top;
    import pste_pkg::*;

    localparam int                TREE_DEPTH = 1024;
    localparam logic [FUNC_W-1:0] FUNC_BAD   = 2'd3;
    localparam logic [SUM_W-1:0]  SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0]  SUM_MIN    = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [SUM_W-1:0] total;
        logic             status;
    } t_sum_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [95:0]       s_axis_tdata  = '0;
    logic [1:0]        s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    // predictor state
    logic [SUM_W-1:0]  tree_sums [TREE_DEPTH];
    logic [SIZE_W-1:0] size_reg;
    t_sum_result       sums_expected [$];
    int unsigned       fail_count = 0;
    bit                calm       = 1'b0;

    prefix_sum_tree_engine_core #(.DEPTH(TREE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 29);
    end

    function automatic int unsigned tree_len(logic [SIZE_W-1:0] sz);
        return (sz > TREE_DEPTH) ? TREE_DEPTH : 32'(sz);
    endfunction

    function automatic logic [SUM_W-1:0] prefix_of(int unsigned cnt);
        logic [SUM_W-1:0] acc;
        acc = '0;
        while (cnt > 0) begin
            acc += tree_sums[cnt-1];
            cnt -= cnt & (~cnt + 1);
        end
        return acc;
    endfunction

    function automatic t_sum_result predict_result(logic [FUNC_W-1:0] f, logic [POS_W-1:0] pos,
                                                   logic [SUM_W-1:0] amt, logic [SIZE_W-1:0] lo,
                                                   logic [SIZE_W-1:0] hi);
        t_sum_result r;
        int unsigned n;
        int unsigned k;
        r.total  = '0;
        r.status = 1'b0;
        n = tree_len(size_reg);
        case (f)
            FUNC_ADD: begin
                if (32'(pos) >= n) begin
                    r.status = 1'b1;
                end else begin
                    k = 32'(pos) + 1;
                    while (k <= n) begin
                        tree_sums[k-1] += amt;
                        k += k & (~k + 1);
                    end
                end
            end
            FUNC_PREFIX: begin
                if (32'(hi) > n) r.status = 1'b1;
                else r.total = prefix_of(32'(hi));
            end
            FUNC_RANGE: begin
                if (32'(hi) > n || lo > hi) r.status = 1'b1;
                else r.total = prefix_of(32'(hi)) - prefix_of(32'(lo));
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    // model update on every accepted request, result check on every accepted result
    always @(posedge i_clk) begin : sum_monitor
        t_sum_result want;
        t_sum_result pred;
        if (!i_rst_n) begin
            size_reg = SIZE_W'(TREE_DEPTH);
            foreach (tree_sums[i]) tree_sums[i] = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                size_reg = i_cfg_data;
                foreach (tree_sums[i]) tree_sums[i] = '0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = predict_result(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[73:10],
                                      s_axis_tdata[84:74], s_axis_tdata[95:85]);
                sums_expected = {sums_expected, pred};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sums_expected.size() == 0) begin
                    $error("unexpected result: total %h status %0d", m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    want = sums_expected.pop_front();
                    if (m_axis_tdata !== want.total) begin
                        $error("total mismatch: expected %h, got %h", want.total, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status,
                               m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] pos,
                                input logic [SUM_W-1:0] amt, input logic [SIZE_W-1:0] lo,
                                input logic [SIZE_W-1:0] hi);
        while (!calm && $urandom_range(99) < 29) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo, amt, pos};
        s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sums_expected.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // size writes restart the tree, so only when nothing is in flight
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SUM_W-1:0] rand_amount();
        case ($urandom_range(7))
            0: return SUM_MAX;
            1: return SUM_MIN;
            2: return SUM_W'($signed($urandom_range(200)) - 100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(input int unsigned n);
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
        int unsigned       pick;
        f    = FUNC_BAD;
        pos  = POS_W'($urandom);
        lo   = SIZE_W'($urandom);
        hi   = SIZE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            f = FUNC_ADD;
            if (n > 0) pos = POS_W'($urandom_range(n - 1, 0));
        end else if (pick < 62) begin
            f  = FUNC_PREFIX;
            hi = SIZE_W'($urandom_range(n, 0));
        end else if (pick < 86) begin
            f  = FUNC_RANGE;
            hi = SIZE_W'($urandom_range(n, 0));
            lo = SIZE_W'($urandom_range(32'(hi), 0));
        end else if (pick < 90) begin
            f = FUNC_ADD;
            if (n < TREE_DEPTH) pos = POS_W'($urandom_range(TREE_DEPTH - 1, n));
        end else if (pick < 94) begin
            f  = ($urandom_range(1) != 0) ? FUNC_PREFIX : FUNC_RANGE;
            hi = SIZE_W'($urandom_range(2047, n + 1));
        end else if (pick < 97) begin
            f  = FUNC_RANGE;
            hi = SIZE_W'($urandom_range((n > 0) ? n - 1 : 0, 0));
            lo = SIZE_W'($urandom_range(2047, 32'(hi) + 1));
        end
        send_request(f, pos, rand_amount(), lo, hi);
    endtask

    task automatic test_extremes();
        send_request(FUNC_ADD,    10'd0,    SUM_MAX, 11'd0,    11'd0);
        send_request(FUNC_ADD,    10'd1023, SUM_MIN, 11'd0,    11'd0);
        send_request(FUNC_ADD,    10'd511,  '1,      11'd2047, 11'd2047);
        send_request(FUNC_PREFIX, 10'd0,    '0,      11'd0,    11'd0);
        send_request(FUNC_PREFIX, 10'd0,    '0,      11'd0,    11'd1024);
        send_request(FUNC_PREFIX, 10'd0,    '0,      11'd0,    11'd1);
        send_request(FUNC_RANGE,  10'd0,    '0,      11'd0,    11'd1024);
        send_request(FUNC_RANGE,  10'd0,    '0,      11'd1024, 11'd1024);
        send_request(FUNC_RANGE,  10'd0,    '0,      11'd1,    11'd1023);
        send_request(FUNC_PREFIX, 10'd0,    '0,      11'd0,    11'd1025);
        send_request(FUNC_RANGE,  10'd0,    '0,      11'd5,    11'd4);
        send_request(FUNC_RANGE,  10'd0,    '0,      11'd0,    11'd2047);
        send_request(FUNC_BAD,    10'd3,    SUM_MAX, 11'd0,    11'd8);
    endtask

    task automatic test_empty_tree();
        write_size(11'd0);
        send_request(FUNC_ADD,    10'd0, 64'd5, 11'd0, 11'd0);
        send_request(FUNC_PREFIX, 10'd0, '0,    11'd0, 11'd0);
        send_request(FUNC_RANGE,  10'd0, '0,    11'd0, 11'd0);
        send_request(FUNC_PREFIX, 10'd0, '0,    11'd0, 11'd1);
    endtask

    task automatic test_size_saturation();
        write_size(11'd2047);
        send_request(FUNC_ADD,    10'd1023, 64'd9, 11'd0, 11'd0);
        send_request(FUNC_PREFIX, 10'd0,    '0,    11'd0, 11'd1024);
        send_request(FUNC_PREFIX, 10'd0,    '0,    11'd0, 11'd1025);
    endtask

    task automatic test_single_entry();
        write_size(11'd1);
        send_request(FUNC_ADD,    10'd0, SUM_MAX, 11'd0, 11'd0);
        send_request(FUNC_ADD,    10'd1, 64'd1,   11'd0, 11'd0);
        send_request(FUNC_PREFIX, 10'd0, '0,      11'd0, 11'd1);
    endtask

    task automatic test_random_size(input logic [SIZE_W-1:0] sz, input int unsigned count);
        write_size(sz);
        repeat (count) send_random(tree_len(sz));
    endtask

    task automatic test_back_to_back();
        write_size(11'd64);
        calm = 1'b1;
        repeat (250) send_random(64);
        drain_results();
        calm = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_empty_tree();
        test_size_saturation();
        test_single_entry();
        test_random_size(11'd1024, 450);
        test_random_size(11'd1, 60);
        test_random_size(11'd37, 200);
        test_random_size(11'd2047, 150);
        test_random_size(11'd0, 40);
        test_random_size(11'd300, 250);
        test_back_to_back();
        test_random_size(11'd1024, 120);

        drain_results();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
